// ===== hdl/bsr_pkg.sv =====
// shared types, codes and the sequencer microprogram for the bisection square root
package bsr_pkg;

	localparam int MAX_STEPS_DEF = 48;
	localparam logic [31:0] TOL_RESET = 32'd256;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	// result status codes
	localparam logic [1:0] ST_MID  = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_CAP  = 2'd2;
	localparam logic [1:0] ST_REJ  = 2'd3;

	// microprogram addresses
	typedef logic [1:0] upc_t;
	localparam upc_t UPC_MID = 2'd0;
	localparam upc_t UPC_SQR = 2'd1;
	localparam upc_t UPC_DIF = 2'd2;
	localparam upc_t UPC_CHK = 2'd3;

	typedef struct packed {
		logic ld_mid;
		logic ld_sq;
		logic ld_diff;
		logic check;
		upc_t next_pc;
	} ctrl_t;

	// control store: one word per step of a bisection iteration
	function automatic ctrl_t ucode(input upc_t pc);
		ctrl_t cw;
		cw = '0;
		unique case (pc)
			UPC_MID: begin
				cw.ld_mid = 1'b1;
				cw.next_pc = UPC_SQR;
			end
			UPC_SQR: begin
				cw.ld_sq = 1'b1;
				cw.next_pc = UPC_DIF;
			end
			UPC_DIF: begin
				cw.ld_diff = 1'b1;
				cw.next_pc = UPC_CHK;
			end
			UPC_CHK: begin
				// always jumps back to the midpoint word; the run may also finish here
				cw.check = 1'b1;
				cw.next_pc = UPC_MID;
			end
			default: begin
				cw = '0;
			end
		endcase
		return cw;
	endfunction

endpackage

// ===== hdl/bisection_square_root.sv =====
// bisection square root of an unsigned q16.16 value, run by a microcoded sequencer
//
// usage: drive value and pulse start while busy is low; the item is taken at that
// edge. a nonzero value starts a run and busy rises. every midpoint tried comes
// out on midpoint/status/last for one cycle, marked by result_valid; the receiver
// cannot stall, so results must be taken as they appear.
// sequencing: one bisection step is four microprogram words (midpoint, square,
// difference, check) around one 32x32 multiplier, and each check word shows
// one result. a run ends on convergence or after MAX_STEPS results, and a new
// item is taken only once the run is through.
// busy falls as the last result is shown, and a new start may be given in
// that cycle. a zero value is rejected: one result with status 3 and last set
// in the cycle after start, busy stays low.
// tolerance is written through cfg_valid/cfg_ready, ready while not busy.
// reset: asynchronous, active low; clears the sequencer, busy and the strobe,
// and sets tolerance to 256 (2^-8).
module bisection_square_root #(
	parameter int MAX_STEPS = bsr_pkg::MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] tolerance,
	output logic        result_valid,
	output logic [31:0] midpoint,
	output logic [1:0]  status,
	output logic        last
);

	localparam int CntW = $clog2(MAX_STEPS);

	logic              busy_q;
	bsr_pkg::upc_t     pc_q;
	logic [CntW-1:0]   cnt_q;
	logic [31:0]       tol_q;
	logic              result_valid_q;
	logic [31:0]       low_q;
	logic [31:0]       high_q;
	logic [31:0]       target_q;
	logic [31:0]       mid_q;
	logic [63:0]       sq_q;
	logic [63:0]       diff_q;
	logic              gt_q;
	logic [31:0]       midpoint_q;
	logic [1:0]        status_q;
	logic              last_q;

	bsr_pkg::ctrl_t    cw;
	logic              start_acc;
	logic [32:0]       mid_sum;
	logic [63:0]       target_w;
	logic [63:0]       tol_w;
	logic              conv;
	logic              cap;
	logic              fin;

	assign cw        = bsr_pkg::ucode(pc_q);
	assign start_acc = start & ~busy_q;
	assign mid_sum   = {1'b0, low_q} + {1'b0, high_q};
	assign target_w  = {16'b0, target_q, 16'b0};
	assign tol_w     = {16'b0, tol_q, 16'b0};
	assign conv      = diff_q < tol_w;
	assign cap       = cnt_q == CntW'(MAX_STEPS - 1);
	assign fin       = conv | cap;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q <= bsr_pkg::UPC_MID;
			cnt_q <= '0;
			tol_q <= bsr_pkg::TOL_RESET;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_valid && !busy_q) begin
				tol_q <= tolerance;
			end
			if (start_acc) begin
				if (value == 32'd0) begin
					result_valid_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					pc_q <= bsr_pkg::UPC_MID;
					cnt_q <= '0;
				end
			end else if (busy_q) begin
				pc_q <= cw.next_pc;
				if (cw.check) begin
					result_valid_q <= 1'b1;
					cnt_q <= cnt_q + CntW'(1);
					if (fin) begin
						busy_q <= 1'b0;
						pc_q <= bsr_pkg::UPC_MID;
					end
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start_acc) begin
			if (value == 32'd0) begin
				midpoint_q <= 32'd0;
				status_q <= bsr_pkg::ST_REJ;
				last_q <= 1'b1;
			end else begin
				target_q <= value;
				low_q <= 32'd0;
				high_q <= (value > bsr_pkg::ONE_Q16) ? value : bsr_pkg::ONE_Q16;
			end
		end else if (busy_q) begin
			if (cw.ld_mid) begin
				mid_q <= mid_sum[32:1];
			end
			if (cw.ld_sq) begin
				sq_q <= 64'(mid_q) * 64'(mid_q);
			end
			if (cw.ld_diff) begin
				diff_q <= (sq_q >= target_w) ? (sq_q - target_w) : (target_w - sq_q);
				gt_q <= sq_q > target_w;
			end
			if (cw.check) begin
				midpoint_q <= mid_q;
				last_q <= fin;
				status_q <= conv ? bsr_pkg::ST_CONV :
					(cap ? bsr_pkg::ST_CAP : bsr_pkg::ST_MID);
				if (!fin) begin
					// keep the half that holds the root
					if (gt_q) begin
						high_q <= mid_q;
					end else begin
						low_q <= mid_q;
					end
				end
			end
		end
	end

	assign busy         = busy_q;
	assign cfg_ready    = ~busy_q;
	assign result_valid = result_valid_q;
	assign midpoint     = midpoint_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

// ===== hdl/bsr_checker.sv =====
// port-level checks for the bisection square root, bound to the top level
module bsr_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [31:0] value,
	input logic        result_valid,
	input logic [1:0]  status,
	input logic        last
);

	// a zero value gives exactly one rejection result in the next cycle
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && value == 32'd0 |=>
			result_valid && status == bsr_pkg::ST_REJ && last && !busy)
		else $error("zero value not rejected");

	// a nonzero value starts a run
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && value != 32'd0 |=> busy && !result_valid)
		else $error("run did not start");

	// an intermediate result leaves the run going, a final one ends it
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy && status == bsr_pkg::ST_MID)
		else $error("intermediate result outside a run");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("busy after final result");

	// steps inside a run are spaced by the microprogram
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> !result_valid)
		else $error("back-to-back intermediate results");

endmodule

bind bisection_square_root bsr_port_checks u_bsr_port_checks (.*);
